FILE: sv/band_hue_to_rgb_core_macros.svh
// ---------------------------------------------------------------------------
// band_hue_to_rgb_core_macros
// Assertion helpers shared by the band hue to RGB core and its submodules.
// ---------------------------------------------------------------------------
`ifndef BAND_HUE_TO_RGB_CORE_MACROS_SVH
`define BAND_HUE_TO_RGB_CORE_MACROS_SVH

// Check a property on every rising edge outside reset.
`define BHR_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Check a property on every rising edge, reset included.
`define BHR_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

FILE: sv/bhr_pkg.sv
// ---------------------------------------------------------------------------
// bhr_pkg
// Shared widths, constants, register codes and types of the band hue to RGB core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bhr_pkg;

  // Band count limit and the index width it needs.
  localparam int MAX_BANDS = 32;
  localparam int BAND_W    = $clog2(MAX_BANDS);

  // Hue in 1/16 degree, brightness in Q8.
  localparam int HUE_TURN   = 5760;
  localparam int HUE_SECTOR = 960;
  localparam int HUE_BLUE   = 3840;
  localparam int BRIGHT_ONE = 256;
  localparam int LEVEL_MAX  = 255;

  // Field and register widths.
  localparam int HUE_W      = 20;
  localparam int OFS_W      = 14;
  localparam int TB_W       = 6;
  localparam int IDX_W      = 5;
  localparam int BRI_W      = 9;
  localparam int CH_W       = 8;
  localparam int TB_RESET   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  localparam logic [CFG_IDX_W-1:0] REG_HUE_OFFSET  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_BANDS = CFG_IDX_W'(1);

  // Band hue: round(3840 * k / n) = floor((7680 * k + n) / (2 * n)).
  localparam int NUM_W     = $clog2(2 * HUE_BLUE * (MAX_BANDS - 1) + MAX_BANDS);
  localparam int RECIP_W   = NUM_W;
  localparam int RECIP_NUM = 1 << (RECIP_W - 1);
  localparam int RECIP_CNT_W = $clog2(RECIP_W);
  localparam int HB_W      = $clog2(HUE_BLUE + 1);

  // Direct hue: biased to stay positive, then reduced modulo one turn.
  localparam int DIR_TURNS = ((1 << (HUE_W - 1)) + (1 << (OFS_W - 1))) / HUE_TURN + 1;
  localparam int DIR_BIAS  = DIR_TURNS * HUE_TURN;
  localparam int DIR_W     = $clog2((1 << (HUE_W - 1)) + (1 << (OFS_W - 1)) + DIR_BIAS);
  localparam int DIR_M     = (1 << DIR_W) / HUE_TURN;
  localparam int QD_W      = $clog2((1 << DIR_W) / HUE_TURN + 1);
  localparam int H_W       = $clog2(HUE_TURN);
  localparam int RD_W      = $clog2(2 * HUE_TURN);

  // Band hue plus offset, biased by two turns.
  localparam int U_W       = $clog2(HUE_BLUE + (1 << (OFS_W - 1)) + 2 * HUE_TURN);

  // Sector split.
  localparam int SEC_M     = (1 << H_W) / HUE_SECTOR;
  localparam int SEC_W     = 3;
  localparam int FS_W      = $clog2(2 * HUE_SECTOR);
  localparam int T_W       = $clog2(HUE_SECTOR + 1);

  // Levels: full = (510 v + 256) >> 9,
  // part = floor(((510 v t + 245760) >> 15) / 15).
  localparam int FULL_SH   = $clog2(2 * BRIGHT_ONE);
  localparam int VT_W      = $clog2(BRIGHT_ONE * HUE_SECTOR + 1);
  localparam int PART_BIAS = BRIGHT_ONE * HUE_SECTOR;
  localparam int PART_SH   = 15;
  localparam int PART_ODD  = (2 * BRIGHT_ONE * HUE_SECTOR) >> PART_SH;
  localparam int Y_W       = $clog2(((2 * LEVEL_MAX * BRIGHT_ONE * HUE_SECTOR + PART_BIAS)
                                     >> PART_SH) + 1);
  localparam int PART_RS   = Y_W;
  localparam int PART_M    = (1 << PART_RS) / PART_ODD;
  localparam int PQ_W      = $clog2((1 << Y_W) / PART_ODD + 1);

  // Reciprocal unit status toward the pipeline.
  typedef struct packed {
    logic               busy;
    logic [RECIP_W-1:0] value;
  } recip_t;

endpackage

FILE: sv/bhr_recip.sv
// ---------------------------------------------------------------------------
// bhr_recip
// Bit-serial reciprocal of the band divisor: floor(2^(W-1) / n), one bit a cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "band_hue_to_rgb_core_macros.svh"

module bhr_recip (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [bhr_pkg::BAND_W-1:0] divisor,
  output bhr_pkg::recip_t           rc
);

  logic                               busy;
  logic [bhr_pkg::RECIP_CNT_W-1:0]    cnt;
  logic [bhr_pkg::BAND_W-1:0]         rem;
  logic [bhr_pkg::RECIP_W-1:0]        quo;
  logic [bhr_pkg::BAND_W:0]           rem_sh;
  logic                               ge;
  logic [bhr_pkg::BAND_W-1:0]         rem_next;
  logic [31:0]                        chk_lo;

  // Dividend is a single one at its top bit.
  assign rem_sh   = {rem, (cnt == bhr_pkg::RECIP_CNT_W'(bhr_pkg::RECIP_W - 1))};
  assign ge       = (rem_sh >= {1'b0, divisor});
  assign rem_next = ge ? bhr_pkg::BAND_W'(rem_sh - {1'b0, divisor})
                       : bhr_pkg::BAND_W'(rem_sh);

  always_ff @(posedge clk) begin
    if (rst || start) begin
      busy <= 1'b1;
      cnt  <= bhr_pkg::RECIP_CNT_W'(bhr_pkg::RECIP_W - 1);
      rem  <= '0;
      quo  <= '0;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[bhr_pkg::RECIP_W-2:0], ge};
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - bhr_pkg::RECIP_CNT_W'(1);
      end
    end
  end

  assign rc.busy  = busy;
  assign rc.value = quo;

  assign chk_lo = 32'(quo) * 32'(divisor);

  `BHR_ASSERT_ALWAYS(a_rst_busy, clk, rst |=> busy, "reciprocal not restarted by reset")
  `BHR_ASSERT(a_start_busy, clk, rst, start |=> busy, "reciprocal not restarted by write")
  `BHR_ASSERT(a_quo_exact, clk, rst, (!busy && divisor != '0) |-> (chk_lo <= 32'(bhr_pkg::RECIP_NUM) && chk_lo + 32'(divisor) > 32'(bhr_pkg::RECIP_NUM)), "reciprocal is not the floor quotient")

endmodule

FILE: sv/band_hue_to_rgb_core.sv
// ---------------------------------------------------------------------------
// band_hue_to_rgb_core
// Full saturation HSV to RGB for a voxel cube: hue given directly or from a
// band index, rotated by an offset, scaled by a Q8 brightness.
// ---------------------------------------------------------------------------
//
//   channel  handshake              payload
//   -------  ---------------------  ------------------------------------------
//   input    in_valid / in_stall    req_type, hue, band_index, brightness
//   output   out_valid / out_stall  red, green, blue
//   config   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per clock through nine register stages while the output does not
// stall and the band reciprocal is not being rebuilt.
// The depth is set by the chain of reciprocal multiplies: band divide, hue
// modulo, sector split, the brightness product and the final divide by 15.
// Each stage holds only while it is full and the stage after it holds, so
// bubbles close up and a stalled output still lets new items in.
// Reset (rst, synchronous) empties the pipe and loads the register defaults;
// after reset and after every total_bands write the input stalls while the
// band reciprocal is rebuilt one quotient bit a cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "band_hue_to_rgb_core_macros.svh"

module band_hue_to_rgb_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                req_type,
  input  logic signed [bhr_pkg::HUE_W-1:0]    hue,
  input  logic [bhr_pkg::IDX_W-1:0]           band_index,
  input  logic [bhr_pkg::BRI_W-1:0]           brightness,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [bhr_pkg::CH_W-1:0]            red,
  output logic [bhr_pkg::CH_W-1:0]            green,
  output logic [bhr_pkg::CH_W-1:0]            blue,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bhr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bhr_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int NS     = 9;
  localparam int PROD_W = bhr_pkg::NUM_W + bhr_pkg::RECIP_W;

  // Sector codes, named by the channel at full level then the one that ramps.
  localparam logic [bhr_pkg::SEC_W-1:0] SEC_RED_GREEN  = bhr_pkg::SEC_W'(0);
  localparam logic [bhr_pkg::SEC_W-1:0] SEC_GREEN_RED  = bhr_pkg::SEC_W'(1);
  localparam logic [bhr_pkg::SEC_W-1:0] SEC_GREEN_BLUE = bhr_pkg::SEC_W'(2);
  localparam logic [bhr_pkg::SEC_W-1:0] SEC_BLUE_GREEN = bhr_pkg::SEC_W'(3);
  localparam logic [bhr_pkg::SEC_W-1:0] SEC_BLUE_RED   = bhr_pkg::SEC_W'(4);

  // -------------------------------------------------------------------------
  // Configuration registers
  // -------------------------------------------------------------------------
  logic signed [bhr_pkg::OFS_W-1:0] hue_offset;
  logic [bhr_pkg::TB_W-1:0]         total_bands;
  logic                             cfg_fire;
  logic                             recip_start;
  logic [bhr_pkg::BAND_W-1:0]       n_eff;
  bhr_pkg::recip_t                  rc;

  // Hold off config transfers while the reciprocal is being rebuilt.
  assign cfg_ready   = !rc.busy;
  assign cfg_fire    = cfg_valid && cfg_ready;
  assign recip_start = cfg_fire && (cfg_index == bhr_pkg::REG_TOTAL_BANDS);

  always_ff @(posedge clk) begin
    if (rst) begin
      hue_offset  <= '0;
      total_bands <= bhr_pkg::TB_W'(bhr_pkg::TB_RESET);
    end else if (cfg_fire) begin
      case (cfg_index)
        bhr_pkg::REG_HUE_OFFSET: begin
          hue_offset <= signed'(cfg_data[bhr_pkg::OFS_W-1:0]);
        end
        bhr_pkg::REG_TOTAL_BANDS: begin
          total_bands <= cfg_data[bhr_pkg::TB_W-1:0];
        end
        default: begin
          // unknown index: drop the write
        end
      endcase
    end
  end

  // Last band number: bands saturate at MAX_BANDS, zero or one band means n = 0.
  always_comb begin
    if (int'(total_bands) > bhr_pkg::MAX_BANDS) begin
      n_eff = bhr_pkg::BAND_W'(bhr_pkg::MAX_BANDS - 1);
    end else if (total_bands <= bhr_pkg::TB_W'(1)) begin
      n_eff = '0;
    end else begin
      n_eff = bhr_pkg::BAND_W'(total_bands - bhr_pkg::TB_W'(1));
    end
  end

  // Reciprocal of n, rebuilt after reset and after every band count write.
  bhr_recip u_recip (
    .clk     (clk),
    .rst     (rst),
    .start   (recip_start),
    .divisor (n_eff),
    .rc      (rc)
  );

  // -------------------------------------------------------------------------
  // Pipeline flow control
  // -------------------------------------------------------------------------
  // A stage may load when it is empty or when the next stage loads too.
  logic [NS:1] vld;
  logic [NS:1] en;

  always_comb begin
    en[NS] = !vld[NS] || !out_stall;
    for (int k = NS - 1; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_stall  = !en[1] || rc.busy;
  assign out_valid = vld[NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) begin
        vld[1] <= in_valid && !rc.busy;
      end
      for (int k = 2; k <= NS; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Stage 1: clamp index and brightness, form band numerator and biased hue
  // -------------------------------------------------------------------------
  logic [bhr_pkg::BAND_W-1:0] idx_c;
  logic [bhr_pkg::BAND_W-1:0] k_d;
  logic [bhr_pkg::NUM_W-1:0]  num_d;
  logic [bhr_pkg::DIR_W-1:0]  x_d;
  logic [bhr_pkg::BRI_W-1:0]  v_d;

  always_comb begin
    if (int'(band_index) > int'(n_eff)) begin
      idx_c = n_eff;
    end else begin
      idx_c = bhr_pkg::BAND_W'(band_index);
    end
    k_d   = n_eff - idx_c;
    num_d = bhr_pkg::NUM_W'(int'(k_d) * (2 * bhr_pkg::HUE_BLUE) + int'(n_eff));
    x_d   = bhr_pkg::DIR_W'(int'(hue) + int'(hue_offset) + bhr_pkg::DIR_BIAS);
    v_d   = (brightness > bhr_pkg::BRI_W'(bhr_pkg::BRIGHT_ONE)) ?
            bhr_pkg::BRI_W'(bhr_pkg::BRIGHT_ONE) : brightness;
  end

  logic                       mode_s1;
  logic [bhr_pkg::NUM_W-1:0]  num_s1;
  logic [bhr_pkg::DIR_W-1:0]  x_s1;
  logic [bhr_pkg::BRI_W-1:0]  v_s1;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      mode_s1 <= req_type;
      num_s1  <= num_d;
      x_s1    <= x_d;
      v_s1    <= v_d;
    end
  end

  // -------------------------------------------------------------------------
  // Stage 2: multiply by the reciprocals (band n, one turn)
  // -------------------------------------------------------------------------
  logic                       mode_s2;
  logic [PROD_W-1:0]          prod_s2;
  logic [bhr_pkg::QD_W-1:0]   qd_s2;
  logic [bhr_pkg::NUM_W-1:0]  num_s2;
  logic [bhr_pkg::DIR_W-1:0]  x_s2;
  logic [bhr_pkg::BRI_W-1:0]  v_s2;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      mode_s2 <= mode_s1;
      prod_s2 <= PROD_W'(num_s1) * PROD_W'(rc.value);
      qd_s2   <= bhr_pkg::QD_W'((32'(x_s1) * 32'(bhr_pkg::DIR_M)) >> bhr_pkg::DIR_W);
      num_s2  <= num_s1;
      x_s2    <= x_s1;
      v_s2    <= v_s1;
    end
  end

  // -------------------------------------------------------------------------
  // Stage 3: correct both quotient estimates by one
  // -------------------------------------------------------------------------
  logic [bhr_pkg::HB_W-1:0]   qe;
  logic [bhr_pkg::BAND_W:0]   twice_n;
  logic [bhr_pkg::NUM_W-1:0]  rem_b;
  logic [bhr_pkg::HB_W-1:0]   base_d;
  logic [bhr_pkg::RD_W-1:0]   rd;
  logic [bhr_pkg::H_W-1:0]    hd_d;

  always_comb begin
    qe      = prod_s2[bhr_pkg::NUM_W +: bhr_pkg::HB_W];
    twice_n = {n_eff, 1'b0};
    rem_b   = num_s2 - bhr_pkg::NUM_W'(int'(qe) * int'(twice_n));
    if (n_eff == '0) begin
      base_d = '0;
    end else if (rem_b >= bhr_pkg::NUM_W'(twice_n)) begin
      base_d = qe + bhr_pkg::HB_W'(1);
    end else begin
      base_d = qe;
    end
    rd = bhr_pkg::RD_W'(int'(x_s2) - int'(qd_s2) * bhr_pkg::HUE_TURN);
    if (rd >= bhr_pkg::RD_W'(bhr_pkg::HUE_TURN)) begin
      hd_d = bhr_pkg::H_W'(rd - bhr_pkg::RD_W'(bhr_pkg::HUE_TURN));
    end else begin
      hd_d = bhr_pkg::H_W'(rd);
    end
  end

  logic                       mode_s3;
  logic [bhr_pkg::HB_W-1:0]   base_s3;
  logic [bhr_pkg::H_W-1:0]    hd_s3;
  logic [bhr_pkg::BRI_W-1:0]  v_s3;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      mode_s3 <= mode_s2;
      base_s3 <= base_d;
      hd_s3   <= hd_d;
      v_s3    <= v_s2;
    end
  end

  // -------------------------------------------------------------------------
  // Stage 4: rotate the band hue and wrap it into one turn, pick the mode
  // -------------------------------------------------------------------------
  // The biased sum spans just over half a turn to just over four turns.
  logic [bhr_pkg::U_W-1:0]    u;
  logic [bhr_pkg::H_W-1:0]    hb;
  logic [bhr_pkg::H_W-1:0]    h_d;

  always_comb begin
    u = bhr_pkg::U_W'(int'(base_s3) + int'(hue_offset) + 2 * bhr_pkg::HUE_TURN);
    if (u >= bhr_pkg::U_W'(4 * bhr_pkg::HUE_TURN)) begin
      hb = bhr_pkg::H_W'(u - bhr_pkg::U_W'(4 * bhr_pkg::HUE_TURN));
    end else if (u >= bhr_pkg::U_W'(3 * bhr_pkg::HUE_TURN)) begin
      hb = bhr_pkg::H_W'(u - bhr_pkg::U_W'(3 * bhr_pkg::HUE_TURN));
    end else if (u >= bhr_pkg::U_W'(2 * bhr_pkg::HUE_TURN)) begin
      hb = bhr_pkg::H_W'(u - bhr_pkg::U_W'(2 * bhr_pkg::HUE_TURN));
    end else if (u >= bhr_pkg::U_W'(bhr_pkg::HUE_TURN)) begin
      hb = bhr_pkg::H_W'(u - bhr_pkg::U_W'(bhr_pkg::HUE_TURN));
    end else begin
      hb = bhr_pkg::H_W'(u);
    end
    h_d = mode_s3 ? hb : hd_s3;
  end

  logic [bhr_pkg::H_W-1:0]    h_s4;
  logic [bhr_pkg::BRI_W-1:0]  v_s4;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      h_s4 <= h_d;
      v_s4 <= v_s3;
    end
  end

  // -------------------------------------------------------------------------
  // Stage 5: sector, ramp position and full level
  // -------------------------------------------------------------------------
  logic [bhr_pkg::SEC_W-1:0]  qs;
  logic [bhr_pkg::FS_W-1:0]   f1;
  logic [bhr_pkg::SEC_W-1:0]  sec_d;
  logic [bhr_pkg::T_W-1:0]    f_d;
  logic [bhr_pkg::T_W-1:0]    t_d;
  logic [bhr_pkg::CH_W-1:0]   full_d;

  always_comb begin
    qs = bhr_pkg::SEC_W'((int'(h_s4) * bhr_pkg::SEC_M) >> bhr_pkg::H_W);
    f1 = bhr_pkg::FS_W'(int'(h_s4) - int'(qs) * bhr_pkg::HUE_SECTOR);
    if (f1 >= bhr_pkg::FS_W'(bhr_pkg::HUE_SECTOR)) begin
      sec_d = qs + bhr_pkg::SEC_W'(1);
      f_d   = bhr_pkg::T_W'(f1 - bhr_pkg::FS_W'(bhr_pkg::HUE_SECTOR));
    end else begin
      sec_d = qs;
      f_d   = bhr_pkg::T_W'(f1);
    end
    // Odd sectors ramp down.
    t_d    = sec_d[0] ? (bhr_pkg::T_W'(bhr_pkg::HUE_SECTOR) - f_d) : f_d;
    full_d = bhr_pkg::CH_W'((2 * bhr_pkg::LEVEL_MAX * int'(v_s4) + bhr_pkg::BRIGHT_ONE)
                            >> bhr_pkg::FULL_SH);
  end

  logic [bhr_pkg::SEC_W-1:0]  sec_s5;
  logic [bhr_pkg::T_W-1:0]    t_s5;
  logic [bhr_pkg::CH_W-1:0]   full_s5;
  logic [bhr_pkg::BRI_W-1:0]  v_s5;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      sec_s5  <= sec_d;
      t_s5    <= t_d;
      full_s5 <= full_d;
      v_s5    <= v_s4;
    end
  end

  // -------------------------------------------------------------------------
  // Stage 6: brightness times ramp position
  // -------------------------------------------------------------------------
  logic [bhr_pkg::VT_W-1:0]   vt_s6;
  logic [bhr_pkg::SEC_W-1:0]  sec_s6;
  logic [bhr_pkg::CH_W-1:0]   full_s6;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      vt_s6   <= bhr_pkg::VT_W'(int'(v_s5) * int'(t_s5));
      sec_s6  <= sec_s5;
      full_s6 <= full_s5;
    end
  end

  // -------------------------------------------------------------------------
  // Stage 7: scale by 255 with rounding bias, take out the power of two
  // -------------------------------------------------------------------------
  logic [bhr_pkg::Y_W-1:0]    y_s7;
  logic [bhr_pkg::SEC_W-1:0]  sec_s7;
  logic [bhr_pkg::CH_W-1:0]   full_s7;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      y_s7    <= bhr_pkg::Y_W'((2 * bhr_pkg::LEVEL_MAX * int'(vt_s6) + bhr_pkg::PART_BIAS)
                               >> bhr_pkg::PART_SH);
      sec_s7  <= sec_s6;
      full_s7 <= full_s6;
    end
  end

  // -------------------------------------------------------------------------
  // Stage 8: estimate the divide by the odd factor
  // -------------------------------------------------------------------------
  logic [bhr_pkg::PQ_W-1:0]   pq_s8;
  logic [bhr_pkg::Y_W-1:0]    y_s8;
  logic [bhr_pkg::SEC_W-1:0]  sec_s8;
  logic [bhr_pkg::CH_W-1:0]   full_s8;

  always_ff @(posedge clk) begin
    if (en[8]) begin
      pq_s8   <= bhr_pkg::PQ_W'((int'(y_s7) * bhr_pkg::PART_M) >> bhr_pkg::PART_RS);
      y_s8    <= y_s7;
      sec_s8  <= sec_s7;
      full_s8 <= full_s7;
    end
  end

  // -------------------------------------------------------------------------
  // Stage 9: correct the partial level and route levels to channels
  // -------------------------------------------------------------------------
  logic [bhr_pkg::Y_W-1:0]    pr;
  logic [bhr_pkg::PQ_W-1:0]   part_q;
  logic [bhr_pkg::CH_W-1:0]   part;
  logic [bhr_pkg::CH_W-1:0]   red_d;
  logic [bhr_pkg::CH_W-1:0]   green_d;
  logic [bhr_pkg::CH_W-1:0]   blue_d;

  always_comb begin
    pr = bhr_pkg::Y_W'(int'(y_s8) - int'(pq_s8) * bhr_pkg::PART_ODD);
    if (pr >= bhr_pkg::Y_W'(bhr_pkg::PART_ODD)) begin
      part_q = pq_s8 + bhr_pkg::PQ_W'(1);
    end else begin
      part_q = pq_s8;
    end
    part = (part_q > bhr_pkg::PQ_W'(bhr_pkg::LEVEL_MAX)) ?
           bhr_pkg::CH_W'(bhr_pkg::LEVEL_MAX) : bhr_pkg::CH_W'(part_q);
  end

  always_comb begin
    red_d   = '0;
    green_d = '0;
    blue_d  = '0;
    case (sec_s8)
      SEC_RED_GREEN: begin
        red_d   = full_s8;
        green_d = part;
      end
      SEC_GREEN_RED: begin
        red_d   = part;
        green_d = full_s8;
      end
      SEC_GREEN_BLUE: begin
        green_d = full_s8;
        blue_d  = part;
      end
      SEC_BLUE_GREEN: begin
        green_d = part;
        blue_d  = full_s8;
      end
      SEC_BLUE_RED: begin
        red_d  = part;
        blue_d = full_s8;
      end
      default: begin
        red_d  = full_s8;
        blue_d = part;
      end
    endcase
  end

  // Output register: hold while the consumer stalls.
  always_ff @(posedge clk) begin
    if (en[9]) begin
      red   <= red_d;
      green <= green_d;
      blue  <= blue_d;
    end
  end

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  logic base_ok;
  logic h_ok;
  logic dark_ok;

  assign base_ok = (int'(base_s3) <= bhr_pkg::HUE_BLUE);
  assign h_ok    = (int'(h_s4) < bhr_pkg::HUE_TURN);
  assign dark_ok = (red == '0) || (green == '0) || (blue == '0);

  `BHR_ASSERT(a_recip_blocks_input, clk, rst, rc.busy |-> in_stall, "input open in rebuild")
  `BHR_ASSERT(a_band_hue_range, clk, rst, (vld[3] && mode_s3) |-> base_ok, "band hue past blue")
  `BHR_ASSERT(a_hue_wrapped, clk, rst, vld[4] |-> h_ok, "hue not wrapped into one turn")
  `BHR_ASSERT(a_dark_channel, clk, rst, out_valid |-> dark_ok, "no channel is dark")

endmodule
